// File: rtl/ccgd_pkg.sv
package ccgd_pkg;

  // Default sizing of the coin store
  localparam int DEF_SLOTS      = 6;
  localparam int DEF_COUNT_BITS = 10;

  // Fixed field widths
  localparam int SLOT_BITS      = 3;
  localparam int OP_BITS        = 3;
  localparam int AMT_BITS       = 16;
  localparam int STATUS_BITS    = 2;
  localparam int NUM_DENOM_REGS = 6;

  // Command codes
  typedef enum logic [OP_BITS-1:0] {
    OP_DEPOSIT  = 3'd0,
    OP_WITHDRAW = 3'd1,
    OP_ESCROW   = 3'd2,
    OP_COMMIT   = 3'd3,
    OP_CHECK    = 3'd4,
    OP_DISPENSE = 3'd5,
    OP_CLEAR    = 3'd6
  } op_t;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_NOEXACT = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_SAT     = 2'd2;

  // Broadcast command from the front end to every cell
  typedef struct packed {
    logic                 start;
    op_t                  op;
    logic [SLOT_BITS-1:0] slot;
  } cmd_t;

  // Greedy walk token handed from one cell to the next lower one
  typedef struct packed {
    logic                valid;
    op_t                 op;
    logic [AMT_BITS-1:0] rem;
  } tok_t;

  // Result word offered by a cell (count travels beside it)
  typedef struct packed {
    logic                   valid;
    logic [SLOT_BITS-1:0]   slot;
    logic [AMT_BITS-1:0]    rem;
    logic [STATUS_BITS-1:0] status;
    logic                   last;
  } res_t;

endpackage

// File: rtl/coin_change_greedy_dispenser_unit.sv
// Coin store with greedy change making. Commands arrive as stream words on the
// s_ side and results leave on the m_ side, tlast on the final result of each
// command. Each denomination slot is one cell of a chain holding its store and
// escrow counts; change walks pass an amount token from the highest slot down.
// Deposit, withdraw, escrow insert and clear each give one result; commit
// gives SLOTS results. Check runs, in each slot with a nonzero denomination,
// walk entry, a 16-step serial divider in the cell, a multiply, then a subtract
// that hands the token on; an unused slot skips the divider. Dispense does the
// same and in each slot also hands over its result before passing the token on.
// Any stall on m_tready holds a command up further.
// A new command is taken only after the last result of the previous one has
// been handed to the output register. Denominations are written over APB at
// byte address 4*slot and read back there; no clearing pass is needed.
module coin_change_greedy_dispenser_unit import ccgd_pkg::*; #(
  parameter  int SLOTS      = DEF_SLOTS,
  parameter  int COUNT_BITS = DEF_COUNT_BITS,
  localparam int IN_RAW     = OP_BITS + SLOT_BITS + COUNT_BITS + AMT_BITS,
  localparam int IN_W       = ((IN_RAW + 7) / 8) * 8,
  localparam int OUT_RAW    = SLOT_BITS + COUNT_BITS + AMT_BITS + STATUS_BITS,
  localparam int OUT_W      = ((OUT_RAW + 7) / 8) * 8,
  localparam int ADDR_W     = $clog2(4 * NUM_DENOM_REGS)
) (
  input  logic              clk,
  input  logic              rst,
  // s_tdata: opcode, slot, quantity, amount
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,
  // m_tdata: out_slot, coin_count, remaining, status
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,
  output logic              m_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IDX_W = ADDR_W - 2;
  localparam logic [SLOT_BITS:0] SLOT_LIM = (SLOT_BITS + 1)'(SLOTS);

  // Denomination registers
  logic [AMT_BITS-1:0] denom [SLOTS];
  logic [IDX_W-1:0]    reg_idx;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        denom[i] <= '0;
      end
    end else if (cfg_wr) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (i < NUM_DENOM_REGS && reg_idx == IDX_W'(i)) begin
          denom[i] <= pwdata[AMT_BITS-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (i < NUM_DENOM_REGS && reg_idx == IDX_W'(i)) begin
        prdata = {{(32 - AMT_BITS){1'b0}}, denom[i]};
      end
    end
  end

  // Input word decode
  logic [OP_BITS-1:0]    in_op;
  logic [SLOT_BITS-1:0]  in_slot;
  logic [COUNT_BITS-1:0] in_qty;
  logic [AMT_BITS-1:0]   in_amount;
  logic                  legal;
  logic                  busy;
  cmd_t                  cmd;

  assign in_op     = s_tdata[OP_BITS-1:0];
  assign in_slot   = s_tdata[OP_BITS +: SLOT_BITS];
  assign in_qty    = s_tdata[OP_BITS + SLOT_BITS +: COUNT_BITS];
  assign in_amount = s_tdata[OP_BITS + SLOT_BITS + COUNT_BITS +: AMT_BITS];

  always_comb begin
    legal = 1'b1;
    if (in_op > OP_CLEAR) begin
      legal = 1'b0;
    end else if (in_op < OP_COMMIT && {1'b0, in_slot} >= SLOT_LIM) begin
      legal = 1'b0;
    end
  end

  assign s_tready  = !busy;
  assign cmd.start = s_tvalid && s_tready && legal;
  assign cmd.op    = op_t'(in_op);
  assign cmd.slot  = in_slot;

  // Cell chain
  tok_t                  dn [SLOTS];
  logic                  up [SLOTS];
  res_t                  res [SLOTS];
  logic [COUNT_BITS-1:0] res_count [SLOTS];
  logic                  res_ack;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    tok_t tok_in;
    logic up_in;

    if (g == SLOTS - 1) begin : g_top
      assign tok_in = '0;
    end else begin : g_mid
      assign tok_in = dn[g+1];
    end

    if (g == 0) begin : g_bot
      assign up_in = 1'b0;
    end else begin : g_up
      assign up_in = up[g-1];
    end

    ccgd_cell #(
      .IDX        (g),
      .SLOTS      (SLOTS),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .cmd_qty    (in_qty),
      .cmd_amount (in_amount),
      .denom      (denom[g]),
      .tok_in     (tok_in),
      .up_in      (up_in),
      .tok_out    (dn[g]),
      .up_out     (up[g]),
      .res_ack    (res_ack),
      .res        (res[g]),
      .res_count  (res_count[g])
    );
  end

  // At most one cell offers a result; merge them
  res_t                  res_or;
  logic [COUNT_BITS-1:0] count_or;

  always_comb begin
    res_or   = '0;
    count_or = '0;
    for (int i = 0; i < SLOTS; i++) begin
      res_or   = res_or | res[i];
      count_or = count_or | res_count[i];
    end
  end

  assign res_ack = res_or.valid && (!m_tvalid || m_tready);

  // Command in flight until its last result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.start) begin
      busy <= 1'b1;
    end else if (res_ack && res_or.last) begin
      busy <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ack) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      m_tdata <= OUT_W'({res_or.status, res_or.rem, count_or, res_or.slot});
      m_tlast <= res_or.last;
    end
  end

endmodule

// File: rtl/ccgd_cell.sv
module ccgd_cell import ccgd_pkg::*; #(
  parameter int IDX        = 0,
  parameter int SLOTS      = DEF_SLOTS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  logic [COUNT_BITS-1:0] cmd_qty,
  input  logic [AMT_BITS-1:0]   cmd_amount,
  input  logic [AMT_BITS-1:0]   denom,
  input  tok_t                  tok_in,
  input  logic                  up_in,
  output tok_t                  tok_out,
  output logic                  up_out,
  input  logic                  res_ack,
  output res_t                  res,
  output logic [COUNT_BITS-1:0] res_count
);

  localparam int AV_W  = COUNT_BITS + 1;
  localparam int QW    = (AMT_BITS > AV_W) ? AMT_BITS : AV_W;
  localparam int PW    = AV_W + AMT_BITS;
  localparam int CNT_W = $clog2(AMT_BITS);
  localparam logic [SLOT_BITS-1:0] MY_SLOT = SLOT_BITS'(IDX);
  localparam bit IS_TOP = (IDX == SLOTS - 1);
  localparam bit IS_BOT = (IDX == 0);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MUL  = 5'b00100,
    S_FIN  = 5'b01000,
    S_RES  = 5'b10000
  } state_t;

  state_t                 state;
  logic [COUNT_BITS-1:0]  store;
  logic [COUNT_BITS-1:0]  escrow;
  op_t                    op_r;
  logic [AMT_BITS-1:0]    rem_r;
  logic [AMT_BITS-1:0]    dvd;
  logic [AMT_BITS-1:0]    part;
  logic [AMT_BITS-1:0]    quot;
  logic [CNT_W-1:0]       cnt;
  logic [AV_W-1:0]        avail;
  logic [PW-1:0]          prod;
  logic                   clamp;
  logic [COUNT_BITS-1:0]  r_count;
  logic [AMT_BITS-1:0]    r_rem;
  logic [STATUS_BITS-1:0] r_status;
  logic                   r_last;

  // Walk entry: the top cell starts from the command, the others from the token
  logic                walk_go;
  op_t                 walk_op;
  logic [AMT_BITS-1:0] walk_rem;

  always_comb begin
    walk_go  = tok_in.valid;
    walk_op  = tok_in.op;
    walk_rem = tok_in.rem;
    if (IS_TOP && cmd.start && (cmd.op == OP_CHECK || cmd.op == OP_DISPENSE)) begin
      walk_go  = 1'b1;
      walk_op  = cmd.op;
      walk_rem = cmd_amount;
    end
  end

  // Count arithmetic with saturation
  logic            hit;
  logic [AV_W-1:0] dep_sum;
  logic [AV_W-1:0] esc_sum;
  logic [AV_W-1:0] com_sum;
  logic            wd_under;

  assign hit      = (cmd.slot == MY_SLOT);
  assign dep_sum  = {1'b0, store} + {1'b0, cmd_qty};
  assign esc_sum  = {1'b0, escrow} + {1'b0, cmd_qty};
  assign com_sum  = {1'b0, store} + {1'b0, escrow};
  assign wd_under = (cmd_qty > store);

  // One restoring division step per cycle
  logic [AMT_BITS:0] trial;
  logic [AMT_BITS:0] trial_sub;
  logic              trial_ge;

  assign trial     = {part, dvd[AMT_BITS-1]};
  assign trial_sub = trial - {1'b0, denom};
  assign trial_ge  = (trial >= {1'b0, denom});

  // Coins taken and amount left once quotient and product are known
  logic [AV_W-1:0]     take_w;
  logic [AMT_BITS-1:0] new_rem;

  assign take_w  = clamp ? avail : AV_W'(quot);
  assign new_rem = clamp ? (rem_r - prod[AMT_BITS-1:0]) : part;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      store   <= '0;
      escrow  <= '0;
      tok_out <= '0;
      up_out  <= 1'b0;
    end else begin
      tok_out.valid <= 1'b0;
      up_out        <= 1'b0;

      // Broadcast commands that need no walk
      if (cmd.start) begin
        unique case (cmd.op)
          OP_DEPOSIT: begin
            if (hit) begin
              op_r     <= cmd.op;
              store    <= dep_sum[COUNT_BITS] ? '1 : dep_sum[COUNT_BITS-1:0];
              r_count  <= dep_sum[COUNT_BITS] ? '1 : dep_sum[COUNT_BITS-1:0];
              r_status <= dep_sum[COUNT_BITS] ? ST_SAT : ST_OK;
              r_rem    <= '0;
              r_last   <= 1'b1;
              state    <= S_RES;
            end
          end
          OP_WITHDRAW: begin
            if (hit) begin
              op_r     <= cmd.op;
              store    <= wd_under ? '0 : store - cmd_qty;
              r_count  <= wd_under ? '0 : store - cmd_qty;
              r_status <= wd_under ? ST_SAT : ST_OK;
              r_rem    <= '0;
              r_last   <= 1'b1;
              state    <= S_RES;
            end
          end
          OP_ESCROW: begin
            if (hit) begin
              op_r     <= cmd.op;
              escrow   <= esc_sum[COUNT_BITS] ? '1 : esc_sum[COUNT_BITS-1:0];
              r_count  <= esc_sum[COUNT_BITS] ? '1 : esc_sum[COUNT_BITS-1:0];
              r_status <= esc_sum[COUNT_BITS] ? ST_SAT : ST_OK;
              r_rem    <= '0;
              r_last   <= 1'b1;
              state    <= S_RES;
            end
          end
          OP_COMMIT: begin
            // all cells merge at once; results leave from slot 0 upward
            op_r     <= cmd.op;
            store    <= com_sum[COUNT_BITS] ? '1 : com_sum[COUNT_BITS-1:0];
            escrow   <= '0;
            r_count  <= com_sum[COUNT_BITS] ? '1 : com_sum[COUNT_BITS-1:0];
            r_status <= com_sum[COUNT_BITS] ? ST_SAT : ST_OK;
            r_rem    <= '0;
            r_last   <= IS_TOP;
            if (IS_BOT) begin
              state <= S_RES;
            end
          end
          OP_CLEAR: begin
            op_r  <= cmd.op;
            store <= '0;
            if (IS_BOT) begin
              r_count  <= '0;
              r_status <= ST_OK;
              r_rem    <= '0;
              r_last   <= 1'b1;
              state    <= S_RES;
            end
          end
          default: begin
          end
        endcase
      end

      // Commit result moves up the chain
      if (up_in) begin
        state <= S_RES;
      end

      // Greedy walk enters this cell
      if (walk_go) begin
        op_r  <= walk_op;
        rem_r <= walk_rem;
        dvd   <= walk_rem;
        cnt   <= '0;
        avail <= (walk_op == OP_CHECK) ? com_sum : {1'b0, store};
        if (denom == '0) begin
          // unused slot gives nothing
          part  <= walk_rem;
          quot  <= '0;
          state <= S_MUL;
        end else begin
          part  <= '0;
          quot  <= '0;
          state <= S_DIV;
        end
      end

      unique case (state)
        S_IDLE: begin
        end
        S_DIV: begin
          part <= trial_ge ? trial_sub[AMT_BITS-1:0] : trial[AMT_BITS-1:0];
          quot <= {quot[AMT_BITS-2:0], trial_ge};
          dvd  <= {dvd[AMT_BITS-2:0], 1'b0};
          cnt  <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(AMT_BITS - 1)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= PW'(avail) * PW'(denom);
          clamp <= (QW'(quot) > QW'(avail));
          state <= S_FIN;
        end
        S_FIN: begin
          if (op_r == OP_DISPENSE) begin
            store    <= store - take_w[COUNT_BITS-1:0];
            r_count  <= take_w[COUNT_BITS-1:0];
            r_rem    <= new_rem;
            r_status <= (IS_BOT && new_rem != '0) ? ST_NOEXACT : ST_OK;
            r_last   <= IS_BOT;
            state    <= S_RES;
          end else if (IS_BOT) begin
            r_count  <= '0;
            r_rem    <= new_rem;
            r_status <= (new_rem != '0) ? ST_NOEXACT : ST_OK;
            r_last   <= 1'b1;
            state    <= S_RES;
          end else begin
            // check passes silently down to slot 0
            tok_out.valid <= 1'b1;
            tok_out.op    <= op_r;
            tok_out.rem   <= new_rem;
            state         <= S_IDLE;
          end
        end
        S_RES: begin
          if (res_ack) begin
            state <= S_IDLE;
            if (op_r == OP_COMMIT && !IS_TOP) begin
              up_out <= 1'b1;
            end
            if (op_r == OP_DISPENSE && !IS_BOT) begin
              tok_out.valid <= 1'b1;
              tok_out.op    <= op_r;
              tok_out.rem   <= r_rem;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result word, zero unless this cell holds one
  always_comb begin
    res       = '0;
    res_count = '0;
    if (state == S_RES) begin
      res.valid  = 1'b1;
      res.slot   = MY_SLOT;
      res.rem    = r_rem;
      res.status = r_status;
      res.last   = r_last;
      res_count  = r_count;
    end
  end

endmodule

// File: rtl/ccgd_checker.sv
module ccgd_checker import ccgd_pkg::*; #(
  parameter  int COUNT_BITS = DEF_COUNT_BITS,
  localparam int IN_RAW     = OP_BITS + SLOT_BITS + COUNT_BITS + AMT_BITS,
  localparam int IN_W       = ((IN_RAW + 7) / 8) * 8,
  localparam int OUT_RAW    = SLOT_BITS + COUNT_BITS + AMT_BITS + STATUS_BITS,
  localparam int OUT_W      = ((OUT_RAW + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [IN_W-1:0]  s_tdata,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tlast
);

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid after reset");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result word changed");

  // A command that always answers blocks the next word
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready &&
    (s_tdata[2:0] == OP_COMMIT || s_tdata[2:0] == OP_CHECK ||
     s_tdata[2:0] == OP_DISPENSE || s_tdata[2:0] == OP_CLEAR) |=> !s_tready)
    else $error("input taken while a command is in flight");

  // Input stays closed between results of one command
  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input opened before the last result");

endmodule

bind coin_change_greedy_dispenser_unit ccgd_checker #(.COUNT_BITS(COUNT_BITS)) u_ccgd_checker (.*);

// File: dv/coin_change_greedy_dispenser_unit_test.sv
module coin_change_greedy_dispenser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ccgd_pkg::*;

  localparam int SLOTS       = DEF_SLOTS;
  localparam int CNT_W       = DEF_COUNT_BITS;
  localparam int CNT_MAX     = (1 << CNT_W) - 1;
  localparam int SETTLE_CYC  = 200;
  localparam int HOLD_CYC    = 400;
  localparam int CYCLE_LIMIT = 1000000;

  // opcode the block has no use for
  localparam logic [OP_BITS-1:0] OP_UNUSED = 3'd7;

  // command word, opcode in the lowest bits
  typedef struct packed {
    logic [AMT_BITS-1:0]  amount;
    logic [CNT_W-1:0]     qty;
    logic [SLOT_BITS-1:0] slot;
    logic [OP_BITS-1:0]   op;
  } coin_cmd_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0]   slot;
    logic [CNT_W-1:0]       count;
    logic [AMT_BITS-1:0]    rem;
    logic [STATUS_BITS-1:0] status;
    logic                   last;
  } coin_res_t;

  // one command to send, optionally with a fixed expected result
  typedef struct {
    coin_cmd_t cmd;
    bit        fixed;
    coin_res_t want;
  } coin_stim_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // opcode, slot, quantity, amount
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // out_slot, coin_count, remaining, status
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predicted block state
  logic [CNT_W-1:0]    store_cnt  [SLOTS];
  logic [CNT_W-1:0]    escrow_cnt [SLOTS];
  logic [AMT_BITS-1:0] denom_val  [SLOTS];

  coin_stim_t cmd_q [$];
  coin_res_t  results_due [$];
  coin_res_t  got, want;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int err_cnt        = 0;
  int word_cnt       = 0;
  int cycle_cnt      = 0;
  bit hold_arm       = 1'b0;
  bit hold_on        = 1'b0;

  coin_change_greedy_dispenser_unit #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (CNT_W)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void push_due(int slot, int cnt, int rem, logic [STATUS_BITS-1:0] st,
                                   bit last);
    coin_res_t r;
    r.slot   = SLOT_BITS'(slot);
    r.count  = CNT_W'(cnt);
    r.rem    = AMT_BITS'(rem);
    r.status = st;
    r.last   = last;
    results_due.push_back(r);
  endfunction

  // predicted effect of one accepted command
  task automatic apply_coin_cmd(input coin_cmd_t c);
    int s, sum, rem, take, avail, d;
    s = c.slot;
    case (c.op)
      OP_DEPOSIT: if (s < SLOTS) begin
        sum = int'(store_cnt[s]) + int'(c.qty);
        store_cnt[s] = CNT_W'((sum > CNT_MAX) ? CNT_MAX : sum);
        push_due(s, store_cnt[s], 0, (sum > CNT_MAX) ? ST_SAT : ST_OK, 1'b1);
      end
      OP_WITHDRAW: if (s < SLOTS) begin
        if (c.qty > store_cnt[s]) begin
          store_cnt[s] = '0;
          push_due(s, 0, 0, ST_SAT, 1'b1);
        end else begin
          store_cnt[s] = store_cnt[s] - c.qty;
          push_due(s, store_cnt[s], 0, ST_OK, 1'b1);
        end
      end
      OP_ESCROW: if (s < SLOTS) begin
        sum = int'(escrow_cnt[s]) + int'(c.qty);
        escrow_cnt[s] = CNT_W'((sum > CNT_MAX) ? CNT_MAX : sum);
        push_due(s, escrow_cnt[s], 0, (sum > CNT_MAX) ? ST_SAT : ST_OK, 1'b1);
      end
      OP_COMMIT: begin
        for (int i = 0; i < SLOTS; i++) begin
          sum = int'(store_cnt[i]) + int'(escrow_cnt[i]);
          store_cnt[i]  = CNT_W'((sum > CNT_MAX) ? CNT_MAX : sum);
          escrow_cnt[i] = '0;
          push_due(i, store_cnt[i], 0, (sum > CNT_MAX) ? ST_SAT : ST_OK, i == SLOTS - 1);
        end
      end
      OP_CHECK: begin
        // walk over store plus escrow, nothing changes
        rem = c.amount;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          d = denom_val[i];
          if (d != 0) begin
            avail = int'(store_cnt[i]) + int'(escrow_cnt[i]);
            take  = rem / d;
            if (take > avail) take = avail;
            rem -= take * d;
          end
        end
        push_due(0, 0, rem, (rem != 0) ? ST_NOEXACT : ST_OK, 1'b1);
      end
      OP_DISPENSE: begin
        // walk over the store only, highest slot first
        rem = c.amount;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          d = denom_val[i];
          take = 0;
          if (d != 0) begin
            take = rem / d;
            if (take > store_cnt[i]) take = store_cnt[i];
            rem -= take * d;
          end
          store_cnt[i] = store_cnt[i] - CNT_W'(take);
          push_due(i, take, rem, (i == 0 && rem != 0) ? ST_NOEXACT : ST_OK, i == 0);
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) store_cnt[i] = '0;
        push_due(0, 0, 0, ST_OK, 1'b1);
      end
      default: ;
    endcase
  endtask

  task automatic add_row(input logic [OP_BITS-1:0] op, input int slot, input int qty,
                         input int amt, input bit fixed, input int wslot, input int wcnt,
                         input int wrem, input logic [STATUS_BITS-1:0] wst);
    coin_stim_t t;
    t.cmd.op         = op;
    t.cmd.slot       = SLOT_BITS'(slot);
    t.cmd.qty        = CNT_W'(qty);
    t.cmd.amount     = AMT_BITS'(amt);
    t.fixed          = fixed;
    t.want.slot      = SLOT_BITS'(wslot);
    t.want.count     = CNT_W'(wcnt);
    t.want.rem       = AMT_BITS'(wrem);
    t.want.status    = wst;
    t.want.last      = 1'b1;
    cmd_q.push_back(t);
  endtask

  // directed table: op, slot, qty, amount, fixed, expected slot/count/rem/status
  task automatic build_directed();
    add_row(OP_DEPOSIT,  0,    0,     0, 1, 0,    0, 0, ST_OK);
    add_row(OP_DEPOSIT,  5, 1023,     0, 1, 5, 1023, 0, ST_OK);
    add_row(OP_DEPOSIT,  5,    1,     0, 1, 5, 1023, 0, ST_SAT);
    add_row(OP_WITHDRAW, 1,    1,     0, 1, 1,    0, 0, ST_SAT);
    add_row(OP_ESCROW,   2, 1023,     0, 1, 2, 1023, 0, ST_OK);
    add_row(OP_ESCROW,   2,    7,     0, 1, 2, 1023, 0, ST_SAT);
    // slot out of range and unused opcode give nothing back
    add_row(OP_DEPOSIT,  6,    5,     0, 0, 0,    0, 0, ST_OK);
    add_row(OP_ESCROW,   7, 1023, 65535, 0, 0,    0, 0, ST_OK);
    add_row(OP_WITHDRAW, 6,    1,     0, 0, 0,    0, 0, ST_OK);
    add_row(OP_UNUSED,   7, 1023, 65535, 0, 0,    0, 0, ST_OK);
    // slot with zero denomination still counts coins
    add_row(OP_DEPOSIT,  4,    3,     0, 1, 4,    3, 0, ST_OK);
    add_row(OP_DEPOSIT,  2, 1000,     0, 1, 2, 1000, 0, ST_OK);
    add_row(OP_COMMIT,   0,    0,     0, 0, 0,    0, 0, ST_OK);
    add_row(OP_DEPOSIT,  0,   10,     0, 0, 0,    0, 0, ST_OK);
    add_row(OP_DEPOSIT,  1,    4,     0, 0, 0,    0, 0, ST_OK);
    add_row(OP_DEPOSIT,  3,    2,     0, 0, 0,    0, 0, ST_OK);
    add_row(OP_ESCROW,   3,    5,     0, 0, 0,    0, 0, ST_OK);
    add_row(OP_CHECK,    0,    0,   150, 0, 0,    0, 0, ST_OK);
    add_row(OP_CHECK,    0,    0, 65535, 0, 0,    0, 0, ST_OK);
    add_row(OP_DISPENSE, 0,    0, 65535, 0, 0,    0, 0, ST_OK);
    add_row(OP_DISPENSE, 0,    0,     1, 0, 0,    0, 0, ST_OK);
    add_row(OP_DISPENSE, 0,    0,     0, 0, 0,    0, 0, ST_OK);
    add_row(OP_DISPENSE, 0,    0, 65534, 0, 0,    0, 0, ST_OK);
    add_row(OP_WITHDRAW, 5, 1023,     0, 0, 0,    0, 0, ST_OK);
    add_row(OP_CLEAR,    0,    0,     0, 1, 0,    0, 0, ST_OK);
    add_row(OP_CHECK,    0,    0,     0, 1, 0,    0, 0, ST_OK);
    // escrow survives a clear
    add_row(OP_CHECK,    0,    0,     7, 0, 0,    0, 0, ST_OK);
    add_row(OP_COMMIT,   0,    0,     0, 0, 0,    0, 0, ST_OK);
  endtask

  function automatic coin_cmd_t rand_cmd(input bit noise);
    coin_cmd_t c;
    int pick, sum;
    c.op     = OP_CHECK;
    c.slot   = SLOT_BITS'($urandom_range(0, SLOTS - 1));
    c.qty    = ($urandom_range(9) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(0, 40));
    c.amount = AMT_BITS'($urandom);
    if (noise) begin
      if ($urandom_range(1) == 1) begin
        c.op = OP_UNUSED;
      end else begin
        c.op   = OP_BITS'($urandom_range(0, 2));
        c.slot = SLOT_BITS'($urandom_range(SLOTS, 7));
      end
      return c;
    end
    pick = $urandom_range(99);
    if (pick < 28)      c.op = OP_DEPOSIT;
    else if (pick < 38) c.op = OP_WITHDRAW;
    else if (pick < 52) c.op = OP_ESCROW;
    else if (pick < 60) c.op = OP_COMMIT;
    else if (pick < 76) c.op = OP_CHECK;
    else if (pick < 96) c.op = OP_DISPENSE;
    else                c.op = OP_CLEAR;
    // change amounts: small, a sum of a few coins, or anything
    pick = $urandom_range(9);
    if (pick < 4) begin
      c.amount = AMT_BITS'($urandom_range(0, 400));
    end else if (pick < 7) begin
      sum = 0;
      repeat ($urandom_range(1, 4)) sum += denom_val[$urandom_range(0, SLOTS - 1)];
      c.amount = AMT_BITS'(sum);
    end
    return c;
  endfunction

  // APB write: setup then access; the caller closes the transfer
  task automatic apb_write(input int idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(4 * idx);
    pwdata  <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    denom_val[idx] = val;
  endtask

  task automatic load_denoms(input logic [16*SLOTS-1:0] set);
    for (int i = 0; i < SLOTS; i++) apb_write(i, set[16*i +: 16]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // offer queued words, predicting each one at acceptance
  task automatic send_all();
    coin_stim_t it;
    while (cmd_q.size() != 0) begin
      it = cmd_q.pop_front();
      if ($urandom_range(99) < src_idle_pct) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= it.cmd;
      do @(posedge clk); while (!s_tready);
      apply_coin_cmd(it.cmd);
      if (it.fixed) begin
        void'(results_due.pop_back());
        results_due.push_back(it.want);
      end
    end
    s_tvalid <= 1'b0;
  endtask

  task automatic run_random(input int n, input int src_pct, input int sink_pct);
    int valid_cnt;
    coin_stim_t t;
    src_idle_pct   = src_pct;
    sink_stall_pct <= sink_pct;
    valid_cnt = 0;
    t.fixed = 1'b0;
    t.want  = '0;
    while (valid_cnt < n) begin
      if ($urandom_range(99) < 6) begin
        t.cmd = rand_cmd(1'b1);
      end else begin
        t.cmd = rand_cmd(1'b0);
        valid_cnt++;
      end
      cmd_q.push_back(t);
    end
    send_all();
  endtask

  // wait for all results, then for any command still being worked on
  task automatic settle();
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // receiver backpressure
  always @(posedge clk) begin
    if (hold_on) m_tready <= 1'b0;
    else         m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // one long hold-off on the result side
  initial begin
    wait (hold_arm);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk);
    hold_on <= 1'b0;
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.slot   = m_tdata[2:0];
      got.count  = m_tdata[12:3];
      got.rem    = m_tdata[28:13];
      got.status = m_tdata[30:29];
      got.last   = m_tlast;
      word_cnt++;
      if (results_due.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("word %0d: unexpected result slot %0d count %0d rem %0d st %0d last %0d",
                   word_cnt, got.slot, got.count, got.rem, got.status, got.last);
      end else begin
        want = results_due.pop_front();
        if (got.slot !== want.slot || got.count !== want.count || got.rem !== want.rem ||
            got.status !== want.status || got.last !== want.last) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("word %0d: exp slot %0d count %0d rem %0d st %0d last %0d, got %0d %0d %0d %0d %0d",
                     word_cnt, want.slot, want.count, want.rem, want.status, want.last,
                     got.slot, got.count, got.rem, got.status, got.last);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("coin_change_greedy_dispenser_unit test failed");
      $finish;
    end
  end

  initial begin
    logic [16*SLOTS-1:0] rnd_set;
    int acc;
    for (int i = 0; i < SLOTS; i++) begin
      store_cnt[i]  = '0;
      escrow_cnt[i] = '0;
      denom_val[i]  = '0;
    end
    build_directed();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows, unused slot 4 and a full-scale top coin
    load_denoms({16'd65535, 16'd0, 16'd25, 16'd10, 16'd5, 16'd1});
    send_all();
    settle();

    // random phases: none, sender idle, receiver stall, both
    load_denoms({16'd100, 16'd50, 16'd25, 16'd10, 16'd5, 16'd1});
    run_random(38, 0, 0);
    settle();

    load_denoms({16'd50, 16'd20, 16'd10, 16'd5, 16'd2, 16'd1});
    run_random(38, 52, 0);
    settle();

    acc = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if ($urandom_range(3) == 0) begin
        rnd_set[16*i +: 16] = '0;
      end else begin
        acc += $urandom_range(1, 60);
        rnd_set[16*i +: 16] = 16'(acc);
      end
    end
    load_denoms(rnd_set);
    run_random(38, 0, 52);
    settle();

    load_denoms({16'd65535, 16'd40000, 16'd0, 16'd2, 16'd1, 16'd1});
    run_random(38, 25, 25);
    settle();

    // all slots unused, receiver held off so the input backs up
    load_denoms('0);
    hold_arm = 1'b1;
    run_random(25, 0, 0);
    settle();

    if (err_cnt == 0 && results_due.size() == 0) begin
      $display("coin_change_greedy_dispenser_unit test passed");
    end else begin
      $display("coin_change_greedy_dispenser_unit test failed");
    end
    $finish;
  end

endmodule
